FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the bus decoder modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression holds at every clock edge outside reset.
`define SBBD_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sbbd assertion failed");
// When the condition holds, the expression holds in the same cycle.
`define SBBD_ASSERT_IMPL(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("sbbd assertion failed");
// When the condition holds, the expression holds in the next cycle.
`define SBBD_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("sbbd assertion failed");
`else
`define SBBD_ASSERT(label, expr)
`define SBBD_ASSERT_IMPL(label, cond, expr)
`define SBBD_ASSERT_NEXT(label, cond, expr)
`endif
`endif

FILE: rtl/core/sbbd_pkg.sv
// Shared types and constants of the sound CPU bus decoder.
// Used by the front decoder, the command queue, the back end and the top level.
package sbbd_pkg;

   // Sizes.
   localparam int RAM_BYTES   = 2048;
   localparam int RAM_ADDR_W  = $clog2(RAM_BYTES);
   localparam int CART_W      = 22;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int BANK_COUNT  = 4;

   // Memory map boundaries.
   localparam logic [15:0] ADDR_DIRECT_TOP = 16'h7fff;
   localparam logic [15:0] ADDR_WIN14_TOP  = 16'hbfff;
   localparam logic [15:0] ADDR_WIN13_TOP  = 16'hdfff;
   localparam logic [15:0] ADDR_WIN12_TOP  = 16'hefff;
   localparam logic [15:0] ADDR_WIN11_TOP  = 16'hf7ff;
   localparam logic [15:0] ADDR_RAM_BASE   = 16'hf800;

   // Port numbers, low nibble.
   localparam logic [3:0] PORT_LATCH   = 4'h0;
   localparam logic [3:0] PORT_CHIP_LO = 4'h4;
   localparam logic [3:0] PORT_CHIP_HI = 4'h7;
   localparam logic [3:0] PORT_BANK_LO = 4'h8;
   localparam logic [3:0] PORT_BANK_HI = 4'hb;
   localparam logic [3:0] PORT_REPLY   = 4'hc;

   // Port numbers, low five bits, for the NMI enable controls.
   localparam logic [4:0] PORT_NMI_ON_LO = 5'h08;
   localparam logic [4:0] PORT_NMI_ON_HI = 5'h0b;
   localparam logic [4:0] PORT_NMI_OFF   = 5'h18;

   // Bus function codes of an input item.
   typedef enum logic [2:0] {
      FUNC_MEM_READ  = 3'd0,
      FUNC_MEM_WRITE = 3'd1,
      FUNC_PORT_IN   = 3'd2,
      FUNC_PORT_OUT  = 3'd3,
      FUNC_HOST_LATCH = 3'd4
   } func_type;

   // Destination codes of a result item.
   typedef enum logic [1:0] {
      TGT_INTERNAL   = 2'd0,
      TGT_CART_READ  = 2'd1,
      TGT_CHIP_READ  = 2'd2,
      TGT_CHIP_WRITE = 2'd3
   } target_type;

   // Operation classes found by the front decoder.
   typedef enum logic [3:0] {
      OP_NONE        = 4'd0,
      OP_CART_READ   = 4'd1,
      OP_RAM_READ    = 4'd2,
      OP_RAM_WRITE   = 4'd3,
      OP_LATCH_READ  = 4'd4,
      OP_CHIP_READ   = 4'd5,
      OP_BANK_LOAD   = 4'd6,
      OP_NMI_ON      = 4'd7,
      OP_NMI_OFF     = 4'd8,
      OP_LATCH_CLEAR = 4'd9,
      OP_CHIP_WRITE  = 4'd10,
      OP_REPLY_SET   = 4'd11,
      OP_HOST_WRITE  = 4'd12
   } op_type;

   // Cartridge window of a memory read.
   typedef enum logic [2:0] {
      WIN_DIRECT = 3'd0,
      WIN_S14    = 3'd1,
      WIN_S13    = 3'd2,
      WIN_S12    = 3'd3,
      WIN_S11    = 3'd4
   } window_type;

   // Classified item passed from the front to the back.
   typedef struct packed {
      op_type      op;
      window_type  window;
      logic [15:0] address;
      logic [7:0]  data;
   } cmd_type;

endpackage

FILE: rtl/core/sound_cpu_banked_bus_decoder.sv
// Sound CPU bus decoder: banked cartridge windows, local RAM and host mailbox.
// An accepted item is written into the queue, then executed and its result
// registered in the back end's result register. Stalls on rsp_ready delay it.
// Throughput: one item per cycle, executed by the back end, unless rsp_ready stalls.
// Reset clears the bank registers, NMI flags, command and reply latches and
// the command queue; local RAM contents are undefined until written.
module sound_cpu_banked_bus_decoder
   import sbbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_func,
   input  logic [15:0]       req_address,
   input  logic [7:0]        req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_target,
   output logic [CART_W-1:0] rsp_cart_address,
   output logic [1:0]        rsp_chip_port,
   output logic [7:0]        rsp_chip_data,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_nmi_enabled,
   output logic              rsp_nmi_waiting,
   output logic [7:0]        rsp_reply_byte
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    queue_not_full;
   logic    head_valid;
   logic    head_pop;

   // Classify the incoming item.
   sbbd_front u_front (
      .req_func    (req_func),
      .req_address (req_address),
      .req_data    (req_data),
      .cmd         (front_cmd)
   );

   assign req_ready = queue_not_full;

   // Queue between decoder and execution.
   sbbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && queue_not_full),
      .push_cmd  (front_cmd),
      .not_full  (queue_not_full),
      .pop       (head_pop),
      .pop_valid (head_valid),
      .pop_cmd   (head_cmd)
   );

   // Execute items and present results.
   sbbd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (head_valid),
      .cmd              (head_cmd),
      .pop              (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target       (rsp_target),
      .rsp_cart_address (rsp_cart_address),
      .rsp_chip_port    (rsp_chip_port),
      .rsp_chip_data    (rsp_chip_data),
      .rsp_read_data    (rsp_read_data),
      .rsp_nmi_enabled  (rsp_nmi_enabled),
      .rsp_nmi_waiting  (rsp_nmi_waiting),
      .rsp_reply_byte   (rsp_reply_byte)
   );

endmodule

FILE: rtl/core/sbbd_front.sv
// Front decoder: classifies one bus access into an operation and a window.
// Depends on sbbd_pkg.
module sbbd_front
   import sbbd_pkg::*;
(
   input  logic [2:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output cmd_type     cmd
);

   logic [3:0] port_lo;
   logic [4:0] port_lo5;

   assign port_lo  = req_address[3:0];
   assign port_lo5 = req_address[4:0];

   // Decode the function code and address into an operation class.
   always_comb begin
      cmd.op      = OP_NONE;
      cmd.window  = WIN_DIRECT;
      cmd.address = req_address;
      cmd.data    = req_data;
      unique case (req_func)
         FUNC_MEM_READ: begin
            cmd.op = OP_CART_READ;
            if (req_address <= ADDR_DIRECT_TOP) begin
               cmd.window = WIN_DIRECT;
            end else if (req_address <= ADDR_WIN14_TOP) begin
               cmd.window = WIN_S14;
            end else if (req_address <= ADDR_WIN13_TOP) begin
               cmd.window = WIN_S13;
            end else if (req_address <= ADDR_WIN12_TOP) begin
               cmd.window = WIN_S12;
            end else if (req_address <= ADDR_WIN11_TOP) begin
               cmd.window = WIN_S11;
            end else begin
               cmd.op = OP_RAM_READ;
            end
         end
         FUNC_MEM_WRITE: begin
            if (req_address >= ADDR_RAM_BASE) begin
               cmd.op = OP_RAM_WRITE;
            end
         end
         FUNC_PORT_IN: begin
            unique case (port_lo) inside
               PORT_LATCH:                   cmd.op = OP_LATCH_READ;
               [PORT_CHIP_LO:PORT_CHIP_HI]:  cmd.op = OP_CHIP_READ;
               [PORT_BANK_LO:PORT_BANK_HI]:  cmd.op = OP_BANK_LOAD;
               default:                      cmd.op = OP_NONE;
            endcase
         end
         FUNC_PORT_OUT: begin
            // The NMI controls look at five port bits and take precedence.
            if (port_lo5 >= PORT_NMI_ON_LO && port_lo5 <= PORT_NMI_ON_HI) begin
               cmd.op = OP_NMI_ON;
            end else if (port_lo5 == PORT_NMI_OFF) begin
               cmd.op = OP_NMI_OFF;
            end else begin
               unique case (port_lo) inside
                  PORT_LATCH:                  cmd.op = OP_LATCH_CLEAR;
                  [PORT_CHIP_LO:PORT_CHIP_HI]: cmd.op = OP_CHIP_WRITE;
                  PORT_REPLY:                  cmd.op = OP_REPLY_SET;
                  default:                     cmd.op = OP_NONE;
               endcase
            end
         end
         FUNC_HOST_LATCH: begin
            cmd.op = OP_HOST_WRITE;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

FILE: rtl/core/sbbd_queue.sv
// Short command queue between the front decoder and the back end.
// Depends on sbbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbbd_queue
   import sbbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    not_full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign not_full  = (cnt_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SBBD_ASSERT(a_cnt_range, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `SBBD_ASSERT_IMPL(a_pop_nonempty, pop, pop_valid)
   `SBBD_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

FILE: rtl/core/sbbd_back.sv
// Back end: holds the bank registers, NMI flags, latches and local RAM,
// carries out one item per cycle when not stalled and registers its result.
// Depends on sbbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbbd_back
   import sbbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  cmd_type           cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_target,
   output logic [CART_W-1:0] rsp_cart_address,
   output logic [1:0]        rsp_chip_port,
   output logic [7:0]        rsp_chip_data,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_nmi_enabled,
   output logic              rsp_nmi_waiting,
   output logic [7:0]        rsp_reply_byte
);

   // Machine state.
   logic [7:0] bank_ff [BANK_COUNT];
   logic [7:0] bank_in [BANK_COUNT];
   logic       nmi_enable_ff, nmi_enable_in;
   logic       nmi_pending_ff, nmi_pending_in;
   logic [7:0] latch_ff, latch_in;
   logic [7:0] reply_ff, reply_in;
   logic [7:0] ram_mem [RAM_BYTES];
   logic [7:0] ram_q_ff;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        target_ff, target_in;
   logic [CART_W-1:0] cart_ff, cart_in;
   logic [1:0]        port_ff, port_in;
   logic [7:0]        cdata_ff, cdata_in;
   logic [7:0]        rd_ff, rd_in;
   logic              ram_sel_ff, ram_sel_in;

   logic [RAM_ADDR_W-1:0] ram_addr;

   assign ram_addr = cmd.address[RAM_ADDR_W-1:0];

   // An item leaves the queue when the result register is free or being taken.
   assign pop = pop_valid && (!out_valid_ff || rsp_ready);

   // Execute the item at the head of the queue.
   always_comb begin
      for (int i = 0; i < BANK_COUNT; i++) begin
         bank_in[i] = bank_ff[i];
      end
      nmi_enable_in  = nmi_enable_ff;
      nmi_pending_in = nmi_pending_ff;
      latch_in       = latch_ff;
      reply_in       = reply_ff;
      target_in      = TGT_INTERNAL;
      cart_in        = '0;
      port_in        = '0;
      cdata_in       = '0;
      rd_in          = '0;
      ram_sel_in     = 1'b0;
      unique case (cmd.op)
         OP_CART_READ: begin
            target_in = TGT_CART_READ;
            unique case (cmd.window)
               WIN_S14: cart_in = {bank_ff[3], cmd.address[13:0]};
               WIN_S13: cart_in = {1'b0, bank_ff[2], cmd.address[12:0]};
               WIN_S12: cart_in = {2'b0, bank_ff[1], cmd.address[11:0]};
               WIN_S11: cart_in = {3'b0, bank_ff[0], cmd.address[10:0]};
               default: cart_in = {6'b0, cmd.address};
            endcase
         end
         OP_RAM_READ: begin
            ram_sel_in = 1'b1;
         end
         OP_LATCH_READ: begin
            nmi_pending_in = 1'b0;
            rd_in          = latch_ff;
         end
         OP_CHIP_READ: begin
            target_in = TGT_CHIP_READ;
            port_in   = cmd.address[1:0];
         end
         OP_BANK_LOAD: begin
            bank_in[cmd.address[1:0]] = cmd.address[15:8];
         end
         OP_NMI_ON: begin
            nmi_enable_in = 1'b1;
         end
         OP_NMI_OFF: begin
            nmi_enable_in = 1'b0;
         end
         OP_LATCH_CLEAR: begin
            latch_in = '0;
         end
         OP_CHIP_WRITE: begin
            target_in = TGT_CHIP_WRITE;
            port_in   = cmd.address[1:0];
            cdata_in  = cmd.data;
         end
         OP_REPLY_SET: begin
            reply_in = cmd.data;
         end
         OP_HOST_WRITE: begin
            latch_in       = cmd.data;
            nmi_pending_in = 1'b1;
         end
         default: begin
            // Memory writes go to the RAM block below; other items do nothing.
         end
      endcase
   end

   // The result stays until taken; a new one replaces it on a pop.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // State and valid registers, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_COUNT; i++) begin
            bank_ff[i] <= '0;
         end
         nmi_enable_ff  <= 1'b0;
         nmi_pending_ff <= 1'b0;
         latch_ff       <= '0;
         reply_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            for (int i = 0; i < BANK_COUNT; i++) begin
               bank_ff[i] <= bank_in[i];
            end
            nmi_enable_ff  <= nmi_enable_in;
            nmi_pending_ff <= nmi_pending_in;
            latch_ff       <= latch_in;
            reply_ff       <= reply_in;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         target_ff  <= target_in;
         cart_ff    <= cart_in;
         port_ff    <= port_in;
         cdata_ff   <= cdata_in;
         rd_ff      <= rd_in;
         ram_sel_ff <= ram_sel_in;
      end
   end

   // Local RAM with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (pop && cmd.op == OP_RAM_WRITE) begin
         ram_mem[ram_addr] <= cmd.data;
      end
      if (pop && cmd.op == OP_RAM_READ) begin
         ram_q_ff <= ram_mem[ram_addr];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_target       = target_ff;
   assign rsp_cart_address = cart_ff;
   assign rsp_chip_port    = port_ff;
   assign rsp_chip_data    = cdata_ff;
   assign rsp_read_data    = ram_sel_ff ? ram_q_ff : rd_ff;
   assign rsp_nmi_enabled  = nmi_enable_ff;
   assign rsp_nmi_waiting  = nmi_pending_ff;
   assign rsp_reply_byte   = reply_ff;

   `SBBD_ASSERT_IMPL(a_no_pop_on_stall, out_valid_ff && !rsp_ready, !pop)
   `SBBD_ASSERT_NEXT(a_state_held_on_stall, out_valid_ff && !rsp_ready,
                     $stable(nmi_enable_ff) && $stable(nmi_pending_ff) && $stable(reply_ff))
   `SBBD_ASSERT_NEXT(a_pop_gives_result, pop, out_valid_ff)

endmodule
